FILE: rtl/order_free_digest_accumulator_macros.svh
// Assertion macros for the digest accumulator, clocked on clk and held off during reset.
`ifndef ORDER_FREE_DIGEST_ACCUMULATOR_MACROS_SVH
`define ORDER_FREE_DIGEST_ACCUMULATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define ODDA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ODDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ODDA_ASSERT(lbl, cond, msg)
`define ODDA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/odda_pkg.sv
// Shared types and constants of the order-free digest accumulator.
package odda_pkg;

  localparam int ODDA_GROUPS = 16;

  localparam int DIG_W  = 64;
  localparam int CNT_W  = 32;
  localparam int CRC_W  = 32;
  localparam int GRP_FW = 4;
  localparam int COL_W  = 2;
  localparam int COLS   = 4;

  // Mersenne prime 2^31-1
  localparam int M_W = 31;
  localparam logic [M_W-1:0] M31 = 31'h7FFF_FFFF;

  localparam logic CMD_FOLD  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic MODE_SUM  = 1'b0;
  localparam logic MODE_PROD = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_HASH_MODE = 1'b0;

  // queue between front and back; depth must be a power of two
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic             clr;
    logic             inr;
    logic [GRP_FW-1:0] grp;
    logic [COL_W-1:0] col;
    logic [CRC_W-1:0] crc;
    logic             passed;
    logic [M_W-1:0]   mulv;
  } odda_item_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] cnt;
  } odda_qstat_t;

endpackage

FILE: rtl/odda_front.sv
// Front end: takes input transactions, classifies them and pushes them into the queue.
module odda_front #(
  parameter int GROUPS = odda_pkg::ODDA_GROUPS
) (
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [odda_pkg::GRP_FW-1:0] in_group,
  input  logic [odda_pkg::COL_W-1:0]  in_column,
  input  logic [odda_pkg::CRC_W-1:0]  in_crc,
  input  logic                        in_passed,
  input  odda_pkg::odda_qstat_t       q_stat,
  output logic                        q_push,
  output odda_pkg::odda_item_t        q_item
);

  logic [odda_pkg::M_W-1:0] low31;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  // product operand: 0 and 2^31-1 would collapse the digest, so both map to 1
  assign low31 = in_crc[odda_pkg::M_W-1:0];

  always_comb begin
    q_item.clr    = (in_cmd == odda_pkg::CMD_CLEAR);
    q_item.inr    = (32'(in_group) < GROUPS);
    q_item.grp    = in_group;
    q_item.col    = in_column;
    q_item.crc    = in_crc;
    q_item.passed = in_passed;
    if ((low31 == '0) || (low31 == odda_pkg::M31)) begin
      q_item.mulv = odda_pkg::M_W'(1);
    end else begin
      q_item.mulv = low31;
    end
  end

endmodule

FILE: rtl/odda_queue.sv
// Short FIFO between the front end and the update pipeline.
module odda_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  odda_pkg::odda_item_t  push_item,
  input  logic                  pop,
  output odda_pkg::odda_item_t  head,
  output odda_pkg::odda_qstat_t stat
);

  odda_pkg::odda_item_t              ent_r [odda_pkg::QDEPTH];
  logic [odda_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [odda_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [odda_pkg::QCNT_W-1:0]       cnt_r;
  logic                              do_push;
  logic                              do_pop;

  assign stat.cnt   = cnt_r;
  assign stat.full  = (cnt_r == odda_pkg::QCNT_W'(odda_pkg::QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = ent_r[rd_ptr_r];

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/odda_back.sv
// Back end: digest memory, count registers and the fold pipeline with its result register.
module odda_back #(
  parameter int GROUPS = odda_pkg::ODDA_GROUPS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        hash_mode,
  input  odda_pkg::odda_qstat_t       q_stat,
  input  odda_pkg::odda_item_t        q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [odda_pkg::DIG_W-1:0]  out_all_digest,
  output logic [odda_pkg::DIG_W-1:0]  out_pass_digest,
  output logic [odda_pkg::CNT_W-1:0]  out_all_count,
  output logic [odda_pkg::CNT_W-1:0]  out_pass_count
);

  localparam int GRP_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int CW    = odda_pkg::COL_W;
  localparam int ROWS  = GROUPS * odda_pkg::COLS;
  localparam int ROW_W = GRP_W + CW;
  localparam int DW    = odda_pkg::DIG_W;
  localparam int NW    = odda_pkg::CNT_W;
  localparam int MW    = odda_pkg::M_W;
  localparam int PW    = 2 * MW;

  function automatic logic [GRP_W-1:0] grp_of(odda_pkg::odda_item_t it);
    grp_of = GRP_W'(it.grp);
  endfunction

  function automatic logic [ROW_W-1:0] row_of(odda_pkg::odda_item_t it);
    row_of = {GRP_W'(it.grp), it.col};
  endfunction

  // an older transaction in flight that touches the same row, or any row of a cleared group
  function automatic logic conflict(logic v, odda_pkg::odda_item_t a,
                                    odda_pkg::odda_item_t b);
    conflict = v && a.inr && b.inr && (a.grp == b.grp) &&
               (a.clr || b.clr || (a.col == b.col));
  endfunction

  // 2^31 == 1 mod M: add the 31-bit chunks
  function automatic logic [MW+1:0] fold64(logic [DW-1:0] d);
    fold64 = (MW+2)'(d[MW-1:0]) + (MW+2)'(d[2*MW-1:MW]) + (MW+2)'(d[DW-1:2*MW]);
  endfunction

  // below 3*2^31 in, fully reduced out
  function automatic logic [MW-1:0] reduce33(logic [MW+1:0] s);
    logic [MW:0] t;
    t = (MW+1)'(s[MW-1:0]) + (MW+1)'(s[MW+1:MW]);
    if (t >= (MW+1)'(odda_pkg::M31)) begin
      reduce33 = MW'(t - (MW+1)'(odda_pkg::M31));
    end else begin
      reduce33 = t[MW-1:0];
    end
  endfunction

  function automatic logic [MW-1:0] fold62(logic [PW-1:0] p);
    logic [MW:0] t;
    t = (MW+1)'(p[MW-1:0]) + (MW+1)'(p[PW-1:MW]);
    fold62 = reduce33((MW+2)'(t));
  endfunction

  // digest memory, one row per group and column: {pass, all}
  logic [2*DW-1:0] mem [ROWS];
  logic [2*DW-1:0] rd_r;

  logic            row_vld_r  [ROWS];
  logic            grp_init_r [GROUPS];
  logic [NW-1:0]   cnt_all_r  [GROUPS];
  logic [NW-1:0]   cnt_pass_r [GROUPS];

  logic adv;
  logic haz;

  logic                 s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  odda_pkg::odda_item_t s1_it_r, s2_it_r, s3_it_r, s4_it_r;
  logic [DW-1:0]        s2_all_s_r, s2_pass_s_r;
  logic [DW-1:0]        s3_all_s_r, s3_pass_s_r;
  logic [DW-1:0]        s4_all_s_r, s4_pass_s_r;
  logic [MW+1:0]        s2_f1_all_r, s2_f1_pass_r;
  logic [MW-1:0]        s3_r_all_r, s3_r_pass_r;
  logic [PW-1:0]        s4_p_all_r, s4_p_pass_r;

  logic [ROW_W-1:0] s1_row;
  logic [GRP_W-1:0] s1_grp;
  logic [DW-1:0]    old_init, old_all, old_pass, all_s, pass_s;

  logic [ROW_W-1:0] wb_row;
  logic [GRP_W-1:0] wb_grp;
  logic             wb_we, wb_clr, col0;
  logic [MW-1:0]    fin_all, fin_pass;
  logic [DW-1:0]    init_val, all_new, pass_new;
  logic [NW-1:0]    cnt_all_new, cnt_pass_new;

  logic             out_valid_r;
  logic [DW-1:0]    all_dig_r, pass_dig_r, all_dig_nxt, pass_dig_nxt;
  logic [NW-1:0]    all_cnt_r, pass_cnt_r, all_cnt_nxt, pass_cnt_nxt;

  assign adv = !out_valid_r || !out_stall;
  assign haz = conflict(s1_v_r, s1_it_r, q_head) || conflict(s2_v_r, s2_it_r, q_head) ||
               conflict(s3_v_r, s3_it_r, q_head) || conflict(s4_v_r, s4_it_r, q_head);
  assign q_pop = adv && !q_stat.empty && !haz;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_r <= mem[row_of(q_head)];
    end
    if (wb_we) begin
      mem[wb_row] <= {pass_new, all_new};
    end
  end

  // stage 1: old digests (unwritten rows read as the group's initial value)
  assign s1_row   = row_of(s1_it_r);
  assign s1_grp   = grp_of(s1_it_r);
  assign old_init = DW'(grp_init_r[s1_grp]);
  assign old_all  = row_vld_r[s1_row] ? rd_r[DW-1:0] : old_init;
  assign old_pass = row_vld_r[s1_row] ? rd_r[2*DW-1:DW] : old_init;
  assign all_s    = old_all + DW'(s1_it_r.crc);
  assign pass_s   = old_pass + (s1_it_r.passed ? DW'(s1_it_r.crc) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= q_pop;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_it_r      <= q_head;
      s2_it_r      <= s1_it_r;
      s2_all_s_r   <= all_s;
      s2_pass_s_r  <= pass_s;
      s2_f1_all_r  <= fold64(old_all);
      s2_f1_pass_r <= fold64(old_pass);
      s3_it_r      <= s2_it_r;
      s3_all_s_r   <= s2_all_s_r;
      s3_pass_s_r  <= s2_pass_s_r;
      s3_r_all_r   <= reduce33(s2_f1_all_r);
      s3_r_pass_r  <= reduce33(s2_f1_pass_r);
      s4_it_r      <= s3_it_r;
      s4_all_s_r   <= s3_all_s_r;
      s4_pass_s_r  <= s3_pass_s_r;
      s4_p_all_r   <= PW'(s3_r_all_r) * PW'(s3_it_r.mulv);
      s4_p_pass_r  <= PW'(s3_r_pass_r) * PW'(s3_it_r.mulv);
    end
  end

  // stage 4: final reduction and write-back
  assign wb_row   = row_of(s4_it_r);
  assign wb_grp   = grp_of(s4_it_r);
  assign wb_we    = adv && s4_v_r && s4_it_r.inr && !s4_it_r.clr;
  assign wb_clr   = adv && s4_v_r && s4_it_r.inr && s4_it_r.clr;
  assign col0     = (s4_it_r.col == '0);
  assign fin_all  = fold62(s4_p_all_r);
  assign fin_pass = fold62(s4_p_pass_r);
  assign init_val = DW'(hash_mode);

  always_comb begin
    if (hash_mode == odda_pkg::MODE_PROD) begin
      all_new  = DW'(fin_all);
      pass_new = s4_it_r.passed ? DW'(fin_pass) : s4_pass_s_r;
    end else begin
      all_new  = s4_all_s_r;
      pass_new = s4_pass_s_r;
    end
    cnt_all_new  = cnt_all_r[wb_grp] + NW'(col0);
    cnt_pass_new = cnt_pass_r[wb_grp] + NW'(col0 && s4_it_r.passed);
  end

  always_comb begin
    all_dig_nxt  = '0;
    pass_dig_nxt = '0;
    all_cnt_nxt  = '0;
    pass_cnt_nxt = '0;
    if (s4_it_r.inr) begin
      if (s4_it_r.clr) begin
        all_dig_nxt  = init_val;
        pass_dig_nxt = init_val;
      end else begin
        all_dig_nxt  = all_new;
        pass_dig_nxt = pass_new;
        all_cnt_nxt  = cnt_all_new;
        pass_cnt_nxt = cnt_pass_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROWS; i++) begin
        row_vld_r[i] <= 1'b0;
      end
      for (int g = 0; g < GROUPS; g++) begin
        grp_init_r[g] <= odda_pkg::MODE_PROD;
        cnt_all_r[g]  <= '0;
        cnt_pass_r[g] <= '0;
      end
    end else begin
      if (wb_we) begin
        row_vld_r[wb_row]  <= 1'b1;
        cnt_all_r[wb_grp]  <= cnt_all_new;
        cnt_pass_r[wb_grp] <= cnt_pass_new;
      end
      if (wb_clr) begin
        for (int c = 0; c < odda_pkg::COLS; c++) begin
          row_vld_r[{wb_grp, CW'(c)}] <= 1'b0;
        end
        grp_init_r[wb_grp] <= hash_mode;
        cnt_all_r[wb_grp]  <= '0;
        cnt_pass_r[wb_grp] <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s4_v_r) begin
      all_dig_r  <= all_dig_nxt;
      pass_dig_r <= pass_dig_nxt;
      all_cnt_r  <= all_cnt_nxt;
      pass_cnt_r <= pass_cnt_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_all_digest  = all_dig_r;
  assign out_pass_digest = pass_dig_r;
  assign out_all_count   = all_cnt_r;
  assign out_pass_count  = pass_cnt_r;

endmodule

FILE: rtl/order_free_digest_accumulator.sv
// Top level of the order-free digest accumulator: config register, front, queue, back.
// Each input transaction either folds a CRC into one column of a group (cmd 0) or clears
// the group (cmd 1); each gives exactly one result transaction with the updated all and
// pass digests of the addressed column and the group's record counts.
// hash_mode (byte address 0) picks a 64-bit wrapping sum (0) or a product mod 2^31-1 (1).
// Write it only while no transaction is in flight.
// A result passes the queue, the pipeline stages and the result register. Throughput is
// one transaction per cycle while consecutive transactions hit different rows and the
// output is not stalled; a transaction that meets an older one on the same row, or on a
// group being cleared, waits in the queue until that one has written the digest memory,
// so updates to one row never overlap. The memory has one read and one write port per cycle.
// Reset (synchronous, rst_n low) empties the pipeline, sets every digest to 1 and every
// count to 0 through per-row valid bits, and sets hash_mode to 1; no clearing pass.
// A stalled result holds in its output register; the pipeline stops behind it and the
// 4-entry input queue keeps accepting until full, then in_stall rises.
// Groups at or above GROUPS change nothing and return all-zero results.
`include "order_free_digest_accumulator_macros.svh"

module order_free_digest_accumulator #(
  parameter int GROUPS = odda_pkg::ODDA_GROUPS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [odda_pkg::GRP_FW-1:0] in_group,
  input  logic [odda_pkg::COL_W-1:0]  in_column,
  input  logic [odda_pkg::CRC_W-1:0]  in_crc,
  input  logic                        in_passed,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [odda_pkg::DIG_W-1:0]  out_all_digest,
  output logic [odda_pkg::DIG_W-1:0]  out_pass_digest,
  output logic [odda_pkg::CNT_W-1:0]  out_all_count,
  output logic [odda_pkg::CNT_W-1:0]  out_pass_count
);

  logic                  hash_mode_r;
  logic                  cfg_wr;
  logic                  q_push;
  logic                  q_pop;
  odda_pkg::odda_item_t  q_item;
  odda_pkg::odda_item_t  q_head;
  odda_pkg::odda_qstat_t q_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == odda_pkg::REG_HASH_MODE) ? 32'(hash_mode_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_mode_r <= odda_pkg::MODE_PROD;
    end else if (cfg_wr && (paddr[2] == odda_pkg::REG_HASH_MODE)) begin
      hash_mode_r <= pwdata[0];
    end
  end

  odda_front #(
    .GROUPS(GROUPS)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cmd   (in_cmd),
    .in_group (in_group),
    .in_column(in_column),
    .in_crc   (in_crc),
    .in_passed(in_passed),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  odda_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(q_item),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  odda_back #(
    .GROUPS(GROUPS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .hash_mode      (hash_mode_r),
    .q_stat         (q_stat),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_all_digest (out_all_digest),
    .out_pass_digest(out_pass_digest),
    .out_all_count  (out_all_count),
    .out_pass_count (out_pass_count)
  );

  `ODDA_ASSERT(a_pop_nonempty, !(q_pop && q_stat.empty), "back end popped an empty queue")
  `ODDA_ASSERT_NEXT(a_qcnt_up, q_push && !q_pop, q_stat.cnt == $past(q_stat.cnt) + 1'b1, "queue count missed a push")
  `ODDA_ASSERT_NEXT(a_qcnt_dn, q_pop && !q_push, q_stat.cnt == $past(q_stat.cnt) - 1'b1, "queue count missed a pop")

endmodule
